FILE: hdl/mr90_pkg.sv
// ----------------------------------------------------------------------------
// mr90_pkg
// Shared types and constants for the in-place matrix rotation block.
// ----------------------------------------------------------------------------
package mr90_pkg;

	// Fixed field widths of the stream items and the side register.
	localparam int DATA_W = 32;
	localparam int IDX_W  = 5;
	localparam int SIDE_W = 6;
	localparam int ACT_W  = 2;

	// Coordinate width inside the block; a coordinate stays below the side.
	localparam int CW = SIDE_W;

	// Packed stream widths.
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;

	// Item kinds carried in the input tuser.
	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE  = 2'd0,
		ACT_ROTATE = 2'd1,
		ACT_READ   = 2'd2
	} act_t;

	// Front-end control states.
	typedef enum logic [1:0] {
		T_IDLE,
		T_READ,
		T_ROT
	} top_state_t;

	// Rotation walker states.
	typedef enum logic [1:0] {
		W_IDLE,
		W_READ,
		W_WRITE
	} walk_state_t;

	// Memory request and status from the rotation walker.
	typedef struct packed {
		logic          busy;
		logic          done;
		logic          rd;
		logic          wr;
		logic [CW-1:0] row;
		logic [CW-1:0] col;
	} walk_if_t;

endpackage

FILE: hdl/mr90_ram.sv
// ----------------------------------------------------------------------------
// mr90_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mr90_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/mr90_walk.sv
// ----------------------------------------------------------------------------
// mr90_walk
// Rotation sequencer: walks rings and ring positions, reads the four
// elements of each position through the shared memory port, then writes
// them back one place further clockwise.
// ----------------------------------------------------------------------------
module mr90_walk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mr90_pkg::CW-1:0]      side,
	input  logic [mr90_pkg::DATA_W-1:0]  rdata,
	output mr90_pkg::walk_if_t           walk,
	output logic [mr90_pkg::DATA_W-1:0]  wdata
);
	import mr90_pkg::*;

	walk_state_t   state_q, state_d;
	logic [1:0]    phase_q;
	logic [CW-1:0] ring_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] last_q;
	logic [CW-1:0] half_q;
	logic [CW-1:0] mir;
	logic          rd_pend_q;
	logic [1:0]    rd_sel_q;
	logic          done_q;
	logic [1:0]    pos;
	logic          pos_end;
	logic [DATA_W-1:0] hold_q [4];

	// Mirror coordinate of the current ring position: last - (k - ring).
	assign mir = last_q - k_q + ring_q;

	// Reads visit top, right, bottom, left; writes go one place further.
	assign pos = (state_q == W_WRITE) ? (phase_q + 2'd1) : phase_q;

	// Request flags, status and the address of position 0 top, 1 right,
	// 2 bottom, 3 left.
	always_comb begin
		walk.busy = (state_q != W_IDLE);
		walk.done = done_q;
		walk.rd   = (state_q == W_READ);
		walk.wr   = (state_q == W_WRITE);
		case (pos)
			2'd0: begin
				walk.row = ring_q;
				walk.col = k_q;
			end
			2'd1: begin
				walk.row = k_q;
				walk.col = last_q;
			end
			2'd2: begin
				walk.row = last_q;
				walk.col = mir;
			end
			default: begin
				walk.row = mir;
				walk.col = ring_q;
			end
		endcase
	end

	assign wdata     = hold_q[phase_q];
	assign pos_end   = (state_q == W_WRITE) && (phase_q == 2'd3);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			W_IDLE: begin
				if (start && (side > CW'(1))) begin
					state_d = W_READ;
				end
			end
			W_READ: begin
				if (phase_q == 2'd3) begin
					state_d = W_WRITE;
				end
			end
			W_WRITE: begin
				if (phase_q == 2'd3) begin
					if ((k_q + CW'(1) < last_q) || (ring_q + CW'(1) < half_q)) begin
						state_d = W_READ;
					end else begin
						state_d = W_IDLE;
					end
				end
			end
			default: state_d = W_IDLE;
		endcase
	end

	// State, counters and the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= W_IDLE;
			phase_q   <= 2'd0;
			ring_q    <= '0;
			k_q       <= '0;
			last_q    <= '0;
			half_q    <= '0;
			rd_pend_q <= 1'b0;
			rd_sel_q  <= 2'd0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= walk.rd;
			rd_sel_q  <= phase_q;
			done_q    <= 1'b0;
			if (state_q == W_IDLE) begin
				if (start) begin
					phase_q <= 2'd0;
					ring_q  <= '0;
					k_q     <= '0;
					last_q  <= side - CW'(1);
					half_q  <= side >> 1;
					done_q  <= (side <= CW'(1));
				end
			end else begin
				phase_q <= phase_q + 2'd1;
				if (pos_end) begin
					if (k_q + CW'(1) < last_q) begin
						k_q <= k_q + CW'(1);
					end else if (ring_q + CW'(1) < half_q) begin
						ring_q <= ring_q + CW'(1);
						last_q <= last_q - CW'(1);
						k_q    <= ring_q + CW'(1);
					end else begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Capture read data in the cycle after each read request.
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			hold_q[rd_sel_q] <= rdata;
		end
	end

endmodule

FILE: hdl/matrix_rotate_90_inplace.sv
// ----------------------------------------------------------------------------
// matrix_rotate_90_inplace
// Square matrix store with element write and read and an in-place
// 90 degree clockwise rotation of the square in use.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         tuser: action; tdata: row, col, data_in
//  m_*      out        tuser: rotate_done; tdata: data_out
//  cfg_*    in         side_length register write
//
//  A read item goes through the registered read of the matrix memory. A
//  rotation moves each ring position with four reads and four writes on the
//  single memory port. Reset clears the control state; the matrix memory is
//  not cleared. The input is stalled while a result is held and not taken,
//  and while a read or a rotation is under way.
// ----------------------------------------------------------------------------
module matrix_rotate_90_inplace #(
	parameter int MAX_SIDE = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mr90_pkg::S_TDATA_W-1:0] s_tdata,   // row[4:0], col[9:5], data_in[41:10]
	input  logic [mr90_pkg::ACT_W-1:0]     s_tuser,   // action[1:0]
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mr90_pkg::M_TDATA_W-1:0] m_tdata,   // data_out[31:0]
	output logic                           m_tuser,   // rotate_done[0]
	// Side length register.
	input  logic                           cfg_we,
	input  logic [mr90_pkg::SIDE_W-1:0]    cfg_wdata
);
	import mr90_pkg::*;

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	top_state_t        state_q, state_d;
	logic [SIDE_W-1:0] side_q;
	logic [CW-1:0]     n_w;
	logic [IDX_W-1:0]  in_row;
	logic [IDX_W-1:0]  in_col;
	logic [DATA_W-1:0] in_data;
	act_t              in_act;
	logic              in_ok;
	logic              s_xfer;
	logic              fe_wr;
	logic              walk_start;
	logic              zero_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_done_q;
	walk_if_t          walk;
	logic [DATA_W-1:0] walk_wdata;
	logic [CW-1:0]     a_row;
	logic [CW-1:0]     a_col;
	logic [ADDR_W-1:0] addr;
	logic              ram_we;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	// Unpack the input item.
	assign in_act  = act_t'(s_tuser);
	assign in_row  = s_tdata[IDX_W-1:0];
	assign in_col  = s_tdata[2*IDX_W-1:IDX_W];
	assign in_data = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
	assign s_xfer  = s_tvalid && s_tready;

	// Effective side: zero is taken as one, large values clamp to MAX_SIDE.
	always_comb begin
		if (side_q == '0) begin
			n_w = CW'(1);
		end else if (9'(side_q) > 9'(MAX_SIDE)) begin
			n_w = CW'(MAX_SIDE);
		end else begin
			n_w = side_q;
		end
	end

	assign in_ok = (CW'(in_row) < n_w) && (CW'(in_col) < n_w);

	// Side length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_W'(32);
		end else if (cfg_we) begin
			side_q <= cfg_wdata;
		end
	end

	// Front-end control: next state and handshake.
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		fe_wr      = 1'b0;
		walk_start = 1'b0;
		unique case (state_q)
			T_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				if (s_tvalid && s_tready) begin
					unique case (in_act)
						ACT_WRITE:  fe_wr = in_ok;
						ACT_ROTATE: begin
							walk_start = 1'b1;
							state_d    = T_ROT;
						end
						ACT_READ:   state_d = T_READ;
						default:    state_d = T_IDLE;
					endcase
				end
			end
			T_READ: state_d = T_IDLE;
			T_ROT: begin
				if (walk.done) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	// State register, out-of-range read flag and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_xfer) begin
				zero_q <= !in_ok;
			end
			if (state_q == T_READ) begin
				out_valid_q <= 1'b1;
				out_done_q  <= 1'b0;
			end else if (walk.done) begin
				out_valid_q <= 1'b1;
				out_done_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == T_READ) begin
			out_data_q <= zero_q ? '0 : ram_rdata;
		end else if (walk.done) begin
			out_data_q <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_done_q;

	// Memory port: the walker owns it during a rotation.
	assign a_row     = walk.busy ? walk.row : CW'(in_row);
	assign a_col     = walk.busy ? walk.col : CW'(in_col);
	assign addr      = ADDR_W'(32'(a_row) * 32'(MAX_SIDE) + 32'(a_col));
	assign ram_we    = walk.busy ? walk.wr : fe_wr;
	assign ram_wdata = walk.busy ? walk_wdata : in_data;

	mr90_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_start),
		.side   (n_w),
		.rdata  (ram_rdata),
		.walk   (walk),
		.wdata  (walk_wdata)
	);

	mr90_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (ram_wdata),
		.raddr (addr),
		.rdata (ram_rdata)
	);

`ifndef NO_ASSERTIONS
	// The input is never taken while the walker owns the memory port.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		walk.busy |-> !s_tready)
		else $error("input taken during rotation");

	// A rotation ends only while the front end waits for it.
	a_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		walk.done |-> (state_q == T_ROT))
		else $error("rotation done outside rotate state");

	// A new result never overwrites one still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == T_READ) || walk.done) |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// An accepted read moves the front end to the read state in the next cycle.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_xfer && (in_act == ACT_READ)) |=> (state_q == T_READ))
		else $error("read result not produced");
`endif

endmodule

FILE: tb/tb_matrix_rotate_90_inplace.sv
// ----------------------------------------------------------------------------
// tb_matrix_rotate_90_inplace
// Self-checking testbench for the in-place matrix rotation block. A shadow
// copy of the matrix and the side register predicts every read and every
// rotation result. Items go in through bursty input traffic against a
// stalling result side. Stimulus opens with a short directed sequence and
// then runs phases at many side settings: a fill of the square (random cells
// above side 8) followed by random writes, reads, rotations and unused actions.
// ----------------------------------------------------------------------------
module tb_matrix_rotate_90_inplace;
	import mr90_pkg::*;

	localparam int MAX_SIDE = 32;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DRAIN_CYCLES = 20;
	localparam int CFG_SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 55;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// Receiver behavior over a stretch of cycles.
	typedef enum int {
		RX_STEADY,
		RX_CHOPPY,
		RX_SPARSE
	} rx_mode_t;

	// One result as the block reports it.
	typedef struct {
		logic [DATA_W-1:0] data_out;
		logic              rotate_done;
	} result_t;

	// Shadow of the matrix contents and the side register. Each accepted
	// item updates the shadow and queues the result that it should cause.
	class rotation_tracker;
		logic [DATA_W-1:0] cells [MAX_SIDE][MAX_SIDE];
		bit                written [MAX_SIDE][MAX_SIDE];
		int                side;
		result_t           awaited_results [$];
		int                errors;
		int                reported;

		function new();
			side = MAX_SIDE;
			errors = 0;
			reported = 0;
		endfunction

		// A side of zero acts as one, and a side above the maximum acts as the maximum.
		function void set_side(logic [SIDE_W-1:0] value);
			if (value == 0) begin
				side = 1;
			end else if (value > MAX_SIDE) begin
				side = MAX_SIDE;
			end else begin
				side = int'(value);
			end
		endfunction

		function void take_item(logic [ACT_W-1:0] code, logic [IDX_W-1:0] r,
				logic [IDX_W-1:0] c, logic [DATA_W-1:0] d);
			logic [DATA_W-1:0] cells_was [MAX_SIDE][MAX_SIDE];
			bit                written_was [MAX_SIDE][MAX_SIDE];
			bit                in_range;
			result_t           res;
			in_range = (r < side) && (c < side);
			case (code)
				ACT_WRITE: begin
					if (in_range) begin
						cells[r][c] = d;
						written[r][c] = 1'b1;
					end
				end
				ACT_ROTATE: begin
					// Clockwise: the new (i, j) comes from the old (n-1-j, i).
					cells_was = cells;
					written_was = written;
					for (int i = 0; i < side; i++) begin
						for (int j = 0; j < side; j++) begin
							cells[i][j] = cells_was[side-1-j][i];
							written[i][j] = written_was[side-1-j][i];
						end
					end
					res.data_out = '0;
					res.rotate_done = 1'b1;
					awaited_results.push_back(res);
				end
				ACT_READ: begin
					res.data_out = in_range ? cells[r][c] : '0;
					res.rotate_done = 1'b0;
					awaited_results.push_back(res);
				end
				default: begin
				end
			endcase
		endfunction

		// Finds a written element inside the square in use.
		function bit pick_written(output logic [IDX_W-1:0] r, output logic [IDX_W-1:0] c);
			int base;
			int idx;
			for (int t = 0; t < 32; t++) begin
				r = IDX_W'($urandom_range(0, side - 1));
				c = IDX_W'($urandom_range(0, side - 1));
				if (written[r][c])
					return 1'b1;
			end
			base = $urandom_range(0, side * side - 1);
			for (int k = 0; k < side * side; k++) begin
				idx = (base + k) % (side * side);
				r = IDX_W'(idx / side);
				c = IDX_W'(idx % side);
				if (written[r][c])
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_failure(string msg);
			errors++;
			if (reported < 10) begin
				reported++;
				$display("mismatch: %s", msg);
			end
		endfunction

		function void check_result(logic [DATA_W-1:0] data_out, logic rotate_done);
			result_t want;
			if (awaited_results.size() == 0) begin
				note_failure($sformatf("result with nothing awaited: data_out=%h rotate_done=%b",
					data_out, rotate_done));
				return;
			end
			want = awaited_results.pop_front();
			if (data_out !== want.data_out)
				note_failure($sformatf("data_out expected %h actual %h",
					want.data_out, data_out));
			if (rotate_done !== want.rotate_done)
				note_failure($sformatf("rotate_done expected %b actual %b",
					want.rotate_done, rotate_done));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // row[4:0], col[9:5], data_in[41:10]
	logic [ACT_W-1:0]     s_tuser = '0;   // action[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // data_out[31:0]
	logic                 m_tuser;        // rotate_done[0]
	logic                 cfg_we = 1'b0;
	logic [SIDE_W-1:0]    cfg_wdata = '0;

	rotation_tracker expected_matrix = new();
	int idle_cycles = 0;
	int burst_left = 0;

	matrix_rotate_90_inplace #(
		.MAX_SIDE(MAX_SIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls follow their own pattern of steady, choppy and sparse stretches.
	initial begin : rx_pattern
		rx_mode_t mode;
		int span;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 2));
			span = $urandom_range(16, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_STEADY: m_tready <= 1'b1;
					RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
					default:   m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Every result transfer is checked against the oldest awaited result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			expected_matrix.check_result(m_tdata, m_tuser);
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Random word with a bias toward the signed extremes.
	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Drives one item, starting and ending at a falling edge. The sender
	// works in bursts; a gap of idle cycles may open between bursts.
	task automatic send_item(logic [ACT_W-1:0] code, logic [IDX_W-1:0] r,
			logic [IDX_W-1:0] c, logic [DATA_W-1:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - DATA_W - 2 * IDX_W){1'b0}}, d, c, r};
		s_tuser <= code;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_matrix.take_item(code, r, c, d);
		burst_left--;
		@(negedge clk);
	endtask

	// Waits for every awaited result, leaving the input idle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_matrix.awaited_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Side register write, only once the block has gone quiet.
	task automatic write_side(logic [SIDE_W-1:0] value);
		drain();
		repeat (CFG_SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		expected_matrix.set_side(value);
	endtask

	// Coordinates with row or column at or beyond the side in use.
	task automatic outside_coords(output logic [IDX_W-1:0] r, output logic [IDX_W-1:0] c);
		int n;
		n = expected_matrix.side;
		if ($urandom_range(0, 1) == 0) begin
			r = IDX_W'($urandom_range(n, MAX_SIDE - 1));
			c = IDX_W'($urandom);
		end else begin
			r = IDX_W'($urandom);
			c = IDX_W'($urandom_range(n, MAX_SIDE - 1));
		end
	endtask

	// One phase: set the side, fill the square (random writes above side 8), then a random mix of items.
	task automatic run_phase(logic [SIDE_W-1:0] side_value);
		int n;
		int roll;
		int rotate_pct;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		write_side(side_value);
		n = expected_matrix.side;
		rotate_pct = (n <= 8) ? 12 : 4;
		if (n <= 8) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					send_item(ACT_WRITE, IDX_W'(i), IDX_W'(j), random_word());
		end else begin
			repeat (40)
				send_item(ACT_WRITE, IDX_W'($urandom_range(0, n - 1)),
					IDX_W'($urandom_range(0, n - 1)), random_word());
		end
		repeat (PHASE_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < rotate_pct) begin
				send_item(ACT_ROTATE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
			end else if (roll < rotate_pct + 3) begin
				send_item(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
			end else if (roll < 45) begin
				if (n < MAX_SIDE && $urandom_range(0, 9) == 0) begin
					outside_coords(r, c);
				end else begin
					r = IDX_W'($urandom_range(0, n - 1));
					c = IDX_W'($urandom_range(0, n - 1));
				end
				send_item(ACT_WRITE, r, c, random_word());
			end else if (n < MAX_SIDE && $urandom_range(0, 7) == 0) begin
				outside_coords(r, c);
				send_item(ACT_READ, r, c, $urandom);
			end else if (expected_matrix.pick_written(r, c)) begin
				send_item(ACT_READ, r, c, $urandom);
			end else begin
				send_item(ACT_WRITE, IDX_W'($urandom_range(0, n - 1)),
					IDX_W'($urandom_range(0, n - 1)), random_word());
			end
		end
	endtask

	// Main sequence.
	initial begin : stimulus
		logic [SIDE_W-1:0] sides [];
		sides = '{6'd3, 6'd1, 6'd0, 6'd2, 6'd63, 6'd4, 6'd5, 6'd7,
			6'd33, 6'd6, 6'd8, 6'd12, 6'd32, 6'd17};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: corners and signed extremes at the reset side, then rotations.
		send_item(ACT_WRITE, 5'd0, 5'd0, 32'h8000_0000);
		send_item(ACT_WRITE, 5'd0, 5'd31, 32'h7FFF_FFFF);
		send_item(ACT_WRITE, 5'd31, 5'd31, 32'hFFFF_FFFF);
		send_item(ACT_WRITE, 5'd31, 5'd0, 32'h0000_0000);
		send_item(ACT_WRITE, 5'd5, 5'd10, 32'h5A5A_A5A5);
		send_item(ACT_UNUSED, 5'd31, 5'd31, 32'hFFFF_FFFF);
		send_item(ACT_READ, 5'd0, 5'd0, '0);
		send_item(ACT_READ, 5'd0, 5'd31, '0);
		send_item(ACT_READ, 5'd31, 5'd31, '0);
		send_item(ACT_READ, 5'd31, 5'd0, '0);
		send_item(ACT_READ, 5'd5, 5'd10, '0);
		send_item(ACT_ROTATE, '0, '0, '0);
		send_item(ACT_READ, 5'd0, 5'd0, '0);
		send_item(ACT_READ, 5'd0, 5'd31, '0);
		send_item(ACT_READ, 5'd31, 5'd31, '0);
		send_item(ACT_READ, 5'd31, 5'd0, '0);
		send_item(ACT_READ, 5'd10, 5'd26, '0);
		send_item(ACT_ROTATE, 5'd31, 5'd31, 32'hFFFF_FFFF);
		send_item(ACT_READ, 5'd26, 5'd21, '0);

		// Directed: out-of-range write and reads at a small side.
		write_side(6'd2);
		send_item(ACT_WRITE, 5'd2, 5'd0, 32'h1234_5678);
		send_item(ACT_READ, 5'd0, 5'd2, '0);
		send_item(ACT_READ, 5'd31, 5'd31, '0);
		send_item(ACT_READ, 5'd0, 5'd0, '0);

		foreach (sides[i])
			run_phase(sides[i]);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_matrix.errors == 0 && expected_matrix.awaited_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
